@@ src/pctbp_pkg.sv @@
// Shared constants, types and state codes of the per-client token bucket policer.
package pctbp_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam int KEY_W     = 32;
    localparam int TIME_W    = 32;
    localparam int TOK_W     = 24;
    localparam int RATE_W    = 16;
    localparam int PROD_W    = TIME_W + RATE_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = TOK_W;
    localparam int IN_W      = KEY_W + TIME_W + TOK_W;
    localparam int OUT_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 1'd1;

    localparam logic [TOK_W-1:0]  CAPACITY_RST = 24'd25600;
    localparam logic [RATE_W-1:0] RATE_RST     = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    // Hit flag and selected entry, ORed along the row of cells
    typedef struct packed {
        logic              hit;
        logic [TOK_W-1:0]  level;
        logic [TIME_W-1:0] last;
    } chain_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic              look;
        logic              upd_hit;
        logic [KEY_W-1:0]  key;
        logic [TOK_W-1:0]  level;
        logic [TIME_W-1:0] now;
    } cell_ctl_t;

endpackage

@@ src/pctbp_cell.sv @@
// One client bucket entry with its key compare and its link in the select chain.
module pctbp_cell
    import pctbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      wr_new,
    input  chain_t    chain_in,
    output chain_t    chain_out
);

    logic              valid_reg;
    logic              hit_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TOK_W-1:0]  level_reg;
    logic [TIME_W-1:0] last_reg;
    logic              we;

    assign we = wr_new || (ctl.upd_hit && hit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg <= 1'b1;
            end
            if (ctl.look)
            begin
                hit_reg <= valid_reg && (key_reg == ctl.key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_reg   <= ctl.key;
            level_reg <= ctl.level;
            last_reg  <= ctl.now;
        end
    end

    always_comb
    begin
        chain_out.hit   = chain_in.hit | hit_reg;
        chain_out.level = chain_in.level | (hit_reg ? level_reg : '0);
        chain_out.last  = chain_in.last | (hit_reg ? last_reg : '0);
    end

endmodule

@@ src/per_client_token_bucket_policer_top.sv @@
// Top level of the per-client token bucket policer: sequencer, refill datapath, cell row.
//
//   port group   dir  payload (low bit up)                         transfer when
//   s_axis_*     in   client_key[31:0] now_seconds[31:0] cost_q8  tvalid && tready
//   m_axis_*     out  allowed, created, table_full, zero pad       tvalid && tready
//   cfg_*        in   cfg_index selects capacity_q8 / rate_q8      cfg_we high
//
// From its input transfer to its result a request goes through key compare in
// every cell, chain select plus elapsed-time multiply, then refill/clamp/grant and
// write-back. One request is in flight at a time. A waiting result sits in the
// output register; the next request is taken meanwhile and stalls in write-back
// only if that register is still full. Reset clears all valid bits at once.
module per_client_token_bucket_policer_top
    import pctbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // client_key, now_seconds, cost_q8
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // allowed, created, table_full, pad
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    logic [TOK_W-1:0]    capacity_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [CNT_W-1:0]    used_reg;

    logic [KEY_W-1:0]    key_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TOK_W-1:0]    cost_reg;

    logic                hit_reg, full_reg, create_reg;
    logic [TOK_W-1:0]    base_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic                out_valid_reg;
    logic [2:0]          out_flags_reg;

    chain_t              chain [ENTRIES+1];
    cell_ctl_t           ctl;
    logic [ENTRIES-1:0]  wr_new;

    logic                accept;
    logic                commit;
    logic                miss_full;
    logic [TIME_W-1:0]   elapsed;
    logic [SUM_W-1:0]    sum;
    logic [TOK_W-1:0]    clamped;
    logic                grant;
    logic [TOK_W-1:0]    new_level;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_UPD) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-3){1'b0}}, out_flags_reg};

    assign miss_full = !chain[ENTRIES].hit && (used_reg == CNT_W'(ENTRIES));
    assign elapsed   = chain[ENTRIES].hit ? (now_reg - chain[ENTRIES].last) : '0;

    always_comb
    begin
        sum       = SUM_W'(base_reg) + SUM_W'(prod_reg);
        clamped   = (sum > SUM_W'(capacity_reg)) ? capacity_reg : sum[TOK_W-1:0];
        grant     = (clamped >= cost_reg);
        new_level = grant ? (clamped - cost_reg) : clamped;
    end

    always_comb
    begin
        ctl.look    = (state_reg == ST_LOOK);
        ctl.upd_hit = commit && hit_reg;
        ctl.key     = key_reg;
        ctl.level   = new_level;
        ctl.now     = now_reg;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign wr_new[i] = commit && create_reg && (used_reg[IDX_W-1:0] == IDX_W'(i));

        pctbp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_new    (wr_new[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_SEL;
            ST_SEL:  state_next = ST_UPD;
            ST_UPD:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAPACITY_RST;
            rate_reg      <= RATE_RST;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY: capacity_reg <= cfg_data;
                    REG_RATE:     rate_reg     <= cfg_data[RATE_W-1:0];
                    default:      ;
                endcase
            end
            if (commit && create_reg)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            now_reg  <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
            cost_reg <= s_axis_tdata[IN_W-1:KEY_W+TIME_W];
        end
        if (state_reg == ST_SEL)
        begin
            hit_reg    <= chain[ENTRIES].hit;
            full_reg   <= miss_full;
            create_reg <= !chain[ENTRIES].hit && !miss_full;
            base_reg   <= chain[ENTRIES].hit ? chain[ENTRIES].level : capacity_reg;
            prod_reg   <= PROD_W'(elapsed) * PROD_W'(rate_reg);
        end
        if (commit)
        begin
            out_flags_reg <= {full_reg, create_reg, full_reg || grant};
        end
    end

endmodule

@@ src/pctbp_checker.sv @@
// Port-level checks of the policer top level, bound to every instance.
module pctbp_checker
    import pctbp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata
);

    a_full_not_created: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("created and table_full both set");

    a_full_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[0])
        else $error("table_full without allowed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind per_client_token_bucket_policer_top pctbp_checker u_pctbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
